// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the CRC engine RTL.
// Included by files that carry concurrent checks; needs no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/crcwb_pkg.sv =====
// Package of the CRC word/byte engine: widths, register codes, types, helpers.
// Used by every module of the engine; depends on nothing.
`timescale 1ns / 1ps

package crcwb_pkg;

    localparam int CRC_W      = 32;
    localparam int CNT_W      = 3;
    localparam int NUM_BYTES  = 4;
    localparam int IN_TDATA_W = 40;
    localparam int TBL_DEPTH  = 32;
    localparam int TBL_IDX_W  = 5;
    localparam int ADDR_W     = 5;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    localparam logic [CNT_W-1:0] NB_MAX = 3'd4;

    localparam logic [CRC_W-1:0] POLY_RESET       = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] INIT_RESET       = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] FINAL_XOR_RESET  = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_REG_RESET    = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        REG_POLYNOMIAL     = 3'd0,
        REG_INITIAL_VALUE  = 3'd1,
        REG_FINAL_XOR      = 3'd2,
        REG_REFLECT_INPUT  = 3'd3,
        REG_REFLECT_OUTPUT = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        TBL_LOAD,
        TBL_SWEEP,
        TBL_READY
    } tbl_state_t;

    typedef logic [TBL_DEPTH-1:0][CRC_W-1:0] crc_tbl_t;

    typedef struct packed {
        logic [CRC_W-1:0] aligned;
        logic [CNT_W-1:0] nbytes;
        logic             first;
        logic             last;
    } crc_item_t;

    typedef struct packed {
        logic [CRC_W-1:0] initial_value;
        logic [CRC_W-1:0] final_xor;
        logic             reflect_output;
    } back_cfg_t;

    function automatic logic [CRC_W-1:0] bit_reverse(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int k = 0; k < CRC_W; k++)
        begin
            r[k] = v[CRC_W-1-k];
        end
        return r;
    endfunction

endpackage

// ===== rtl/crcwb_table.sv =====
// Sequencer that fills the table of x^(32+j) mod P, j = 0..31, one entry a cycle.
// Runs after reset and after each polynomial write; uses crcwb_pkg.
`timescale 1ns / 1ps

module crcwb_table
    import crcwb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CRC_W-1:0] polynomial,
    input  logic             poly_write,
    output crc_tbl_t         tbl,
    output logic             table_ready
);

    tbl_state_t           state_reg;
    tbl_state_t           state_next;
    logic [TBL_IDX_W-1:0] idx_reg;
    logic [TBL_IDX_W-1:0] idx_next;
    logic [CRC_W-1:0]     cur_reg;
    logic [CRC_W-1:0]     cur_next;
    crc_tbl_t             tbl_reg;
    logic                 load_en;
    logic                 sweep_en;

    always_comb
    begin
        state_next = state_reg;
        if (poly_write)
        begin
            state_next = TBL_LOAD;
        end
        else
        begin
            case (state_reg)
                TBL_LOAD:  state_next = TBL_SWEEP;
                TBL_SWEEP:
                begin
                    if (idx_reg == TBL_IDX_W'(TBL_DEPTH - 1))
                    begin
                        state_next = TBL_READY;
                    end
                end
                TBL_READY: state_next = TBL_READY;
                default:   state_next = TBL_LOAD;
            endcase
        end
    end

    always_comb
    begin
        load_en     = 1'b0;
        sweep_en    = 1'b0;
        table_ready = 1'b0;
        case (state_reg)
            TBL_LOAD:  load_en     = 1'b1;
            TBL_SWEEP: sweep_en    = 1'b1;
            TBL_READY: table_ready = 1'b1;
            default:   load_en     = 1'b1;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        cur_next = cur_reg;
        if (load_en)
        begin
            idx_next = '0;
            cur_next = polynomial;
        end
        else if (sweep_en)
        begin
            idx_next = idx_reg + TBL_IDX_W'(1);
            cur_next = {cur_reg[CRC_W-2:0], 1'b0} ^ (cur_reg[CRC_W-1] ? polynomial : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TBL_LOAD;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (sweep_en)
        begin
            tbl_reg[idx_reg] <= cur_reg;
        end
    end

    assign tbl = tbl_reg;

endmodule

// ===== rtl/crcwb_front.sv =====
// Front end: takes input beats, clamps the byte count and aligns the data bits
// to the order in which they enter the CRC register. Uses crcwb_pkg.
`timescale 1ns / 1ps

module crcwb_front
    import crcwb_pkg::*;
(
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    input  logic                  reflect_input,
    input  logic                  table_ready,
    output logic                  q_valid,
    input  logic                  q_ready,
    output crc_item_t             q_item
);

    logic [CRC_W-1:0] word;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] nbytes;
    logic [CRC_W-1:0] ordered;
    logic [CRC_W-1:0] masked;

    assign word  = s_tdata[CRC_W-1:0];
    assign count = s_tdata[CRC_W+CNT_W-1:CRC_W];

    // Byte i of the word feeds before byte i+1, so it lands in the top byte.
    always_comb
    begin
        nbytes = (count > NB_MAX) ? NB_MAX : count;
        if (reflect_input)
        begin
            ordered = bit_reverse(word);
        end
        else
        begin
            ordered = {word[7:0], word[15:8], word[23:16], word[31:24]};
        end
        for (int p = 0; p < NUM_BYTES; p++)
        begin
            masked[8*p +: 8] = ((CNT_W'(p) + nbytes) >= NB_MAX) ? ordered[8*p +: 8] : 8'h00;
        end
    end

    assign s_tready       = q_ready && table_ready;
    assign q_valid        = s_tvalid && table_ready;
    assign q_item.aligned = masked;
    assign q_item.nbytes  = nbytes;
    assign q_item.first   = s_tuser;
    assign q_item.last    = s_tlast;

endmodule

// ===== rtl/crcwb_queue.sv =====
// Two-entry queue between the front end and the CRC datapath.
// Carries crc_item_t from crcwb_pkg.
`timescale 1ns / 1ps

module crcwb_queue
    import crcwb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  crc_item_t          push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output crc_item_t          pop_item,
    output logic [Q_CNT_W-1:0] count
);

    crc_item_t            mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/crcwb_back.sv =====
// Back end: one table-driven update of the CRC register per item and the
// output register for results. Uses crcwb_pkg and the table from crcwb_table.
`timescale 1ns / 1ps

module crcwb_back
    import crcwb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  crc_item_t        pop_item,
    input  crc_tbl_t         tbl,
    input  back_cfg_t        cfg,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [CRC_W-1:0] m_tdata
);

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CRC_W-1:0] out_data_reg;
    logic [CRC_W-1:0] out_data_next;
    logic [CRC_W-1:0] start;
    logic [CRC_W-1:0] t;
    logic [CRC_W-1:0] prod [NUM_BYTES];
    logic [CRC_W-1:0] high;
    logic             out_free;
    logic             take;

    // t * x^(8k) mod P: the bits shifted past the top fold back through the table.
    always_comb
    begin
        start = pop_item.first ? cfg.initial_value : crc_reg;
        t     = start ^ pop_item.aligned;
        for (int k = 1; k <= NUM_BYTES; k++)
        begin
            high        = t >> (CRC_W - 8 * k);
            prod[k - 1] = t << (8 * k);
            for (int j = 0; j < TBL_DEPTH; j++)
            begin
                if ((j < 8 * k) && high[j])
                begin
                    prod[k - 1] = prod[k - 1] ^ tbl[j];
                end
            end
        end
        case (pop_item.nbytes)
            3'd1:    crc_next = prod[0];
            3'd2:    crc_next = prod[1];
            3'd3:    crc_next = prod[2];
            3'd4:    crc_next = prod[3];
            default: crc_next = t;
        endcase
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign pop_ready = !pop_item.last || out_free;
    assign take      = pop_valid && pop_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (take && pop_item.last)
        begin
            out_valid_next = 1'b1;
            out_data_next  = (cfg.reflect_output ? bit_reverse(crc_next) : crc_next)
                             ^ cfg.final_xor;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_REG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                crc_reg <= crc_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/crc32_word_byte_engine.sv =====
// Top level of the programmable CRC-32 word/byte engine with its register port.
// Depends on crcwb_pkg, crcwb_table, crcwb_front, crcwb_queue, crcwb_back.
//
// Usage:
// The input stream carries one little-endian word per beat with 1 to 4 valid
// bytes; tuser marks the first beat of a message, tlast the last one. A count
// of zero feeds no bytes, a count above four is taken as four.
// The output stream gives one CRC per message, after the beat marked tlast.
// The register port sets polynomial, initial value, final XOR and the two
// reflection switches; registers are to be written only while the engine is
// idle, a rule the engine does not enforce. A last beat passes the queue and
// the result register before its CRC is on m_tdata. Unless stalled, one beat
// is taken per cycle: the whole word enters the CRC register in one update
// through a 32-entry table of x^(32+j) mod P. That table is built one entry a
// cycle, and after reset and after each polynomial write s_tready stays low
// until it is built. The result register and a two-entry queue decouple the
// sides: a stalled receiver holds the result, and beats keep flowing until a
// second last beat must wait. Reset restores the Ethernet CRC-32 settings.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module crc32_word_byte_engine
    import crcwb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // data_word [31:0], byte_count [34:32], zero [39:35]
    input  logic [IN_TDATA_W-1:0] s_tdata,
    // first
    input  logic                  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // crc_result [31:0]
    output logic [CRC_W-1:0]      m_tdata
);

    logic [CRC_W-1:0]   polynomial_reg;
    logic [CRC_W-1:0]   initial_value_reg;
    logic [CRC_W-1:0]   final_xor_reg;
    logic               reflect_input_reg;
    logic               reflect_output_reg;
    logic               cfg_write;
    logic               poly_write;
    cfg_reg_t           reg_sel;
    crc_tbl_t           tbl;
    logic               table_ready;
    logic               q_push_valid;
    logic               q_push_ready;
    crc_item_t          q_push_item;
    logic               pop_valid;
    logic               pop_ready;
    crc_item_t          pop_item;
    logic [Q_CNT_W-1:0] q_count;
    back_cfg_t          back_cfg;

    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign reg_sel    = cfg_reg_t'(paddr[ADDR_W-1:2]);
    assign poly_write = cfg_write && (reg_sel == REG_POLYNOMIAL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            polynomial_reg     <= POLY_RESET;
            initial_value_reg  <= INIT_RESET;
            final_xor_reg      <= FINAL_XOR_RESET;
            reflect_input_reg  <= 1'b1;
            reflect_output_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_POLYNOMIAL:     polynomial_reg     <= pwdata;
                REG_INITIAL_VALUE:  initial_value_reg  <= pwdata;
                REG_FINAL_XOR:      final_xor_reg      <= pwdata;
                REG_REFLECT_INPUT:  reflect_input_reg  <= pwdata[0];
                REG_REFLECT_OUTPUT: reflect_output_reg <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_POLYNOMIAL:     prdata = polynomial_reg;
            REG_INITIAL_VALUE:  prdata = initial_value_reg;
            REG_FINAL_XOR:      prdata = final_xor_reg;
            REG_REFLECT_INPUT:  prdata = {31'd0, reflect_input_reg};
            REG_REFLECT_OUTPUT: prdata = {31'd0, reflect_output_reg};
            default:            prdata = '0;
        endcase
    end

    assign back_cfg.initial_value  = initial_value_reg;
    assign back_cfg.final_xor      = final_xor_reg;
    assign back_cfg.reflect_output = reflect_output_reg;

    crcwb_table u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .polynomial  (polynomial_reg),
        .poly_write  (poly_write),
        .tbl         (tbl),
        .table_ready (table_ready)
    );

    crcwb_front u_front (
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .reflect_input (reflect_input_reg),
        .table_ready   (table_ready),
        .q_valid       (q_push_valid),
        .q_ready       (q_push_ready),
        .q_item        (q_push_item)
    );

    crcwb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .count      (q_count)
    );

    crcwb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .tbl       (tbl),
        .cfg       (back_cfg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `ASSERT_CLK(a_poly_write_stalls_input, clk, rst_n, poly_write |=> !s_tready, "input accepted while the table is rebuilt")

    `ASSERT_NEVER(a_queue_overflow, clk, rst_n, q_count > 2'd2, "queue holds more beats than its depth")

    `ASSERT_CLK(a_result_from_last_beat, clk, rst_n, $rose(m_tvalid) |-> $past(pop_valid && pop_ready && pop_item.last), "result appeared without a last beat")

endmodule
